>>> rtl/tag_list_word_class_matcher_core_defines.svh
// Assertion macros shared by the tag list word-class matcher.
// Every check is clocked on clk and switched off while rst_n is low.
`ifndef TAG_LIST_WORD_CLASS_MATCHER_CORE_DEFINES_SVH
`define TAG_LIST_WORD_CLASS_MATCHER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge.
`define TLWC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// A consequence that must hold in the cycle after its trigger.
`define TLWC_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/tlwc_pkg.sv
`default_nettype none

package tlwc_pkg;

  localparam int CHAR_W       = 16;
  localparam int MASK_W       = 21;
  localparam int TAG_CHARS    = 6;
  localparam int TAG_LEN_W    = $clog2(TAG_CHARS + 2);
  localparam int TAG_IDX_W    = $clog2(TAG_CHARS);
  localparam int NAME_MAX_LEN = 6;
  localparam int NAME_LEN_W   = $clog2(NAME_MAX_LEN + 1);
  localparam int NAME_STR_W   = 8 * NAME_MAX_LEN;
  localparam int NAME_COUNT   = 48;

  localparam logic [CHAR_W-1:0] CHAR_OPEN  = 16'h0028;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE = 16'h0029;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 16'h002C;

  localparam logic [MASK_W-1:0] CLS_NONE    = 21'h000000;
  localparam logic [MASK_W-1:0] CLS_NOUN    = 21'h000001;
  localparam logic [MASK_W-1:0] CLS_V1      = 21'h000002;
  localparam logic [MASK_W-1:0] CLS_V5      = 21'h000004;
  localparam logic [MASK_W-1:0] CLS_V5IKU   = 21'h000008;
  localparam logic [MASK_W-1:0] CLS_V5ARU   = 21'h000010;
  localparam logic [MASK_W-1:0] CLS_VK      = 21'h000020;
  localparam logic [MASK_W-1:0] CLS_VSS     = 21'h000040;
  localparam logic [MASK_W-1:0] CLS_ADJ_F   = 21'h000080;
  localparam logic [MASK_W-1:0] CLS_ADJ_I   = 21'h000100;
  localparam logic [MASK_W-1:0] CLS_ADJ_NA  = 21'h000200;
  localparam logic [MASK_W-1:0] CLS_ADJ_NO  = 21'h000400;
  localparam logic [MASK_W-1:0] CLS_ADJ_PN  = 21'h000800;
  localparam logic [MASK_W-1:0] CLS_ADJ_T   = 21'h001000;
  localparam logic [MASK_W-1:0] CLS_PRIO    = 21'h002000;
  localparam logic [MASK_W-1:0] CLS_ADV     = 21'h004000;
  localparam logic [MASK_W-1:0] CLS_AUX     = 21'h008000;
  localparam logic [MASK_W-1:0] CLS_CONJ    = 21'h010000;
  localparam logic [MASK_W-1:0] CLS_PREF    = 21'h020000;
  localparam logic [MASK_W-1:0] CLS_SUF     = 21'h040000;
  localparam logic [MASK_W-1:0] CLS_VS      = 21'h080000;
  localparam logic [MASK_W-1:0] CLS_PRT     = 21'h100000;

  // Names are stored as ASCII strings, right-justified; the first
  // character sits in the highest occupied byte.
  typedef struct packed {
    logic [NAME_LEN_W-1:0] len;
    logic [NAME_STR_W-1:0] str;
    logic [MASK_W-1:0]     cls;
  } name_t;

  // The open tag as seen by the matcher.
  typedef struct packed {
    logic [TAG_CHARS-1:0][CHAR_W-1:0] chars;
    logic [TAG_LEN_W-1:0]             len;
  } tag_t;

  localparam name_t NAMES [NAME_COUNT] = '{
    '{3'd1, 48'("n"),      CLS_NOUN},
    '{3'd4, 48'("name"),   CLS_NOUN},
    '{3'd1, 48'("P"),      CLS_PRIO},
    '{3'd2, 48'("v1"),     CLS_V1},
    '{3'd2, 48'("v5"),     CLS_V5},
    '{3'd3, 48'("v5b"),    CLS_V5},
    '{3'd3, 48'("v5g"),    CLS_V5},
    '{3'd3, 48'("v5k"),    CLS_V5},
    '{3'd3, 48'("v5m"),    CLS_V5},
    '{3'd3, 48'("v5n"),    CLS_V5},
    '{3'd3, 48'("v5r"),    CLS_V5},
    '{3'd3, 48'("v5s"),    CLS_V5},
    '{3'd3, 48'("v5t"),    CLS_V5},
    '{3'd3, 48'("v5u"),    CLS_V5},
    '{3'd5, 48'("v5k-s"),  CLS_V5IKU},
    '{3'd5, 48'("v5aru"),  CLS_V5ARU},
    '{3'd2, 48'("vk"),     CLS_VK},
    '{3'd2, 48'("vs"),     CLS_VS},
    '{3'd4, 48'("vs-s"),   CLS_VSS},
    '{3'd3, 48'("n-t"),    CLS_NOUN},
    '{3'd3, 48'("adv"),    CLS_ADV},
    '{3'd3, 48'("aux"),    CLS_AUX},
    '{3'd4, 48'("conj"),   CLS_CONJ},
    '{3'd5, 48'("adj-f"),  CLS_ADJ_F},
    '{3'd5, 48'("adj-i"),  CLS_ADJ_I},
    '{3'd6, 48'("adj-na"), CLS_ADJ_NA},
    '{3'd6, 48'("adj-no"), CLS_ADJ_NO},
    '{3'd6, 48'("adj-pn"), CLS_ADJ_PN},
    '{3'd5, 48'("adj-t"),  CLS_ADJ_T},
    '{3'd4, 48'("pref"),   CLS_PREF},
    '{3'd3, 48'("suf"),    CLS_SUF},
    '{3'd3, 48'("prt"),    CLS_PRT},
    '{3'd1, 48'("1"),      CLS_NONE},
    '{3'd1, 48'("2"),      CLS_NONE},
    '{3'd1, 48'("3"),      CLS_NONE},
    '{3'd1, 48'("4"),      CLS_NONE},
    '{3'd1, 48'("5"),      CLS_NONE},
    '{3'd1, 48'("6"),      CLS_NONE},
    '{3'd1, 48'("7"),      CLS_NONE},
    '{3'd1, 48'("8"),      CLS_NONE},
    '{3'd1, 48'("9"),      CLS_NONE},
    '{3'd2, 48'("uk"),     CLS_NONE},
    '{3'd3, 48'("col"),    CLS_NONE},
    '{3'd3, 48'("int"),    CLS_NONE},
    '{3'd3, 48'("obs"),    CLS_NONE},
    '{3'd4, 48'("abbr"),   CLS_NONE},
    '{3'd4, 48'("obsc"),   CLS_NONE},
    '{3'd5, 48'("gikun"),  CLS_NONE}
  };

endpackage

`default_nettype wire

>>> rtl/tlwc_matcher.sv
`default_nettype none

module tlwc_matcher (
  input  tlwc_pkg::tag_t              tag,
  output logic [tlwc_pkg::MASK_W-1:0] class_bits
);
  import tlwc_pkg::*;

  // Every name is compared in parallel; names are distinct, so at most one hits.
  always_comb begin
    logic                  hit;
    logic [NAME_STR_W-1:0] str;
    class_bits = '0;
    for (int n = 0; n < NAME_COUNT; n++) begin
      hit = (TAG_LEN_W'(NAMES[n].len) == tag.len);
      str = NAMES[n].str << (8 * (NAME_MAX_LEN - int'(NAMES[n].len)));
      for (int i = 0; i < NAME_MAX_LEN; i++) begin
        if ((i < int'(NAMES[n].len)) &&
            (tag.chars[i] != {{(CHAR_W-8){1'b0}}, str[NAME_STR_W-1-8*i -: 8]})) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        class_bits = class_bits | NAMES[n].cls;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tag_list_word_class_matcher_core.sv
// Tag list word-class matcher.
//
// The input channel carries one 16-bit character of a dictionary info string
// per transfer, with in_end_of_string marking the terminator. Characters are
// ignored until an opening parenthesis; inside parentheses they build a tag,
// which a comma or closing parenthesis ends and compares against the fixed
// table of tag names. Matching names OR their class bit into a running mask.
// The terminator produces exactly one transfer on the output channel carrying
// that mask, and clears paren flag, tag length and mask; others emit nothing.
//
// One character is taken every clock cycle while the input is not stalled. The
// tag compare is a single parallel pass over the name table between the tag
// registers and the mask register, and the mask appears on the output in the
// cycle after the terminator is taken. The result sits in an output register:
// while it waits, a receiver stall holds it and stalls the input; none is lost.
// A synchronous reset (rst_n low) empties the output register and clears the
// parenthesis flag, tag length and mask; the tag character store needs none.
`default_nettype none
`include "tag_list_word_class_matcher_core_defines.svh"

module tag_list_word_class_matcher_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tlwc_pkg::CHAR_W-1:0] in_character,
  input  logic                        in_end_of_string,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tlwc_pkg::MASK_W-1:0] out_class_mask
);
  import tlwc_pkg::*;

  logic                             in_fire;
  logic                             is_close;
  logic                             is_sep;
  logic                             in_parens_r, in_parens_nxt;
  logic [TAG_LEN_W-1:0]             tag_len_r, tag_len_nxt;
  logic [MASK_W-1:0]                mask_r, mask_nxt;
  logic [TAG_CHARS-1:0][CHAR_W-1:0] tag_chars_r;
  logic                             tag_we;
  logic                             out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]                out_mask_r;
  logic                             out_load;
  tag_t                             tag;
  logic [MASK_W-1:0]                tag_class;

  // The input only waits while a finished mask is held and the receiver stalls.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign is_close = (in_character == CHAR_CLOSE);
  assign is_sep   = is_close || (in_character == CHAR_COMMA);

  assign tag.chars = tag_chars_r;
  assign tag.len   = tag_len_r;

  tlwc_matcher u_matcher (
    .tag        (tag),
    .class_bits (tag_class)
  );

  // Scanner state update for one accepted character.
  always_comb begin
    in_parens_nxt = in_parens_r;
    tag_len_nxt   = tag_len_r;
    mask_nxt      = mask_r;
    tag_we        = 1'b0;
    if (in_fire) begin
      if (in_end_of_string) begin
        in_parens_nxt = 1'b0;
        tag_len_nxt   = '0;
        mask_nxt      = '0;
      end else if (!in_parens_r) begin
        if (in_character == CHAR_OPEN) begin
          in_parens_nxt = 1'b1;
          tag_len_nxt   = '0;
        end
      end else if (is_sep) begin
        // A tag too long for the store has a length past every name and
        // so never matches.
        mask_nxt    = mask_r | tag_class;
        tag_len_nxt = '0;
        if (is_close) begin
          in_parens_nxt = 1'b0;
        end
      end else begin
        tag_we = (tag_len_r < TAG_LEN_W'(TAG_CHARS));
        if (tag_len_r <= TAG_LEN_W'(TAG_CHARS)) begin
          tag_len_nxt = tag_len_r + TAG_LEN_W'(1);
        end
      end
    end
  end

  // Output register: loaded by a terminator, emptied when the receiver takes it.
  always_comb begin
    out_load      = in_fire && in_end_of_string;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_parens_r <= 1'b0;
      tag_len_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_parens_r <= in_parens_nxt;
      tag_len_r   <= tag_len_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_chars_r[tag_len_r[TAG_IDX_W-1:0]] <= in_character;
    end
    if (out_load) begin
      out_mask_r <= mask_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_class_mask = out_mask_r;

  `TLWC_ASSERT_ALWAYS(a_stall_needs_result, !in_stall || out_valid_r)
  `TLWC_ASSERT_ALWAYS(a_tag_len_bounded, tag_len_r <= TAG_LEN_W'(TAG_CHARS + 1))
  `TLWC_ASSERT_NEXT(a_term_emits, rst_n && in_fire && in_end_of_string, out_valid_r && (out_mask_r == $past(mask_r)))
  `TLWC_ASSERT_NEXT(a_term_clears, rst_n && in_fire && in_end_of_string, !in_parens_r && (tag_len_r == '0) && (mask_r == '0))
  `TLWC_ASSERT_NEXT(a_mask_grows, rst_n && !(in_fire && in_end_of_string), (mask_r & $past(mask_r)) == $past(mask_r))

endmodule

`default_nettype wire
